[rtl/psrp_pkg.sv]
// ----------------------------------------------------------------------------
// Port statistics record parser: shared package
// Types and constants used by the front, the record queue and the back end.
// ----------------------------------------------------------------------------
package psrp_pkg;

    // Port limit built into the block; the register can only lower it
    localparam int MAX_PORTS = 16;
    localparam logic [4:0] PORT_CAP = 5'((MAX_PORTS < 16) ? MAX_PORTS : 16);
    localparam logic [4:0] MAX_PORTS_RESET = 5'd16;

    // Byte codes
    localparam logic [7:0] SKIP_BYTE   = 8'h00;
    localparam logic [7:0] NO_PROTOCOL = 8'hFF;

    // Byte positions inside one 8-byte port record
    localparam logic [2:0] POS_PROTOCOL    = 3'd0;
    localparam logic [2:0] POS_CURRENT     = 3'd1;
    localparam logic [2:0] POS_VOLTAGE     = 3'd2;
    localparam logic [2:0] POS_TEMPERATURE = 3'd3;
    localparam logic [2:0] POS_LAST        = 3'd7;

    // Record queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = 2;

    // One complete port record, as handed from front to back
    typedef struct packed {
        logic [3:0] port_number;
        logic [7:0] protocol_code;
        logic [7:0] current_32nds;
        logic [7:0] voltage_8ths;
        logic [7:0] temperature;
    } t_record;

endpackage

[rtl/psrp_front.sv]
// ----------------------------------------------------------------------------
// Port statistics record parser: front
// Accepts payload bytes, skips a leading zero byte, assembles 8-byte records
// and pushes each reportable record into the queue. Holds the port limit.
// ----------------------------------------------------------------------------
module psrp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_payload_byte,
    input  logic               i_last_byte,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [4:0]         i_cfg_data,
    output logic               o_push,
    output psrp_pkg::t_record  o_rec,
    input  logic               i_q_full
);

    logic       r_at_start,  n_at_start;
    logic [2:0] r_pos,       n_pos;
    logic [4:0] r_emitted,   n_emitted;
    logic [4:0] r_max_ports;
    logic [7:0] r_protocol,  n_protocol;
    logic [7:0] r_current,   n_current;
    logic [7:0] r_voltage,   n_voltage;
    logic [7:0] r_temp,      n_temp;

    logic       accept;
    logic       skip;
    logic [4:0] limit;

    // Accept whenever the queue has room for a possible record
    assign o_in_ready  = !i_q_full;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign skip        = r_at_start && (i_payload_byte == psrp_pkg::SKIP_BYTE);
    assign limit       = (r_max_ports < psrp_pkg::PORT_CAP) ? r_max_ports
                                                            : psrp_pkg::PORT_CAP;

    // Push a record on its eighth byte while under the port limit
    assign o_push = accept && !skip && (r_pos == psrp_pkg::POS_LAST) && (r_emitted < limit);
    assign o_rec.port_number   = r_emitted[3:0];
    assign o_rec.protocol_code = r_protocol;
    assign o_rec.current_32nds = r_current;
    assign o_rec.voltage_8ths  = r_voltage;
    assign o_rec.temperature   = r_temp;

    // Next state of the record assembler
    always_comb begin
        n_at_start = r_at_start;
        n_pos      = r_pos;
        n_emitted  = r_emitted;
        n_protocol = r_protocol;
        n_current  = r_current;
        n_voltage  = r_voltage;
        n_temp     = r_temp;
        if (accept) begin
            n_at_start = 1'b0;
            if (!skip) begin
                unique case (r_pos)
                    psrp_pkg::POS_PROTOCOL:    n_protocol = i_payload_byte;
                    psrp_pkg::POS_CURRENT:     n_current  = i_payload_byte;
                    psrp_pkg::POS_VOLTAGE:     n_voltage  = i_payload_byte;
                    psrp_pkg::POS_TEMPERATURE: n_temp     = i_payload_byte;
                    default:                   ;
                endcase
                if (r_pos == psrp_pkg::POS_LAST) begin
                    n_pos = 3'd0;
                    if (o_push) begin
                        n_emitted = r_emitted + 5'd1;
                    end
                end else begin
                    n_pos = r_pos + 3'd1;
                end
            end
            // Return to the start after the final byte
            if (i_last_byte) begin
                n_at_start = 1'b1;
                n_pos      = 3'd0;
                n_emitted  = 5'd0;
            end
        end
    end

    // Control state and port limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_pos       <= 3'd0;
            r_emitted   <= 5'd0;
            r_max_ports <= psrp_pkg::MAX_PORTS_RESET;
        end else begin
            r_at_start <= n_at_start;
            r_pos      <= n_pos;
            r_emitted  <= n_emitted;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_ports <= i_cfg_data;
            end
        end
    end

    // Held record bytes
    always_ff @(posedge i_clk) begin
        r_protocol <= n_protocol;
        r_current  <= n_current;
        r_voltage  <= n_voltage;
        r_temp     <= n_temp;
    end

`ifndef SYNTH
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_last_byte |=> r_at_start && (r_pos == 3'd0) && (r_emitted == 5'd0))
        else $error("front did not return to payload start after final byte");
    a_emitted_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted <= psrp_pkg::PORT_CAP)
        else $error("port count exceeded the built-in cap");
`endif

endmodule

[rtl/psrp_queue.sv]
// ----------------------------------------------------------------------------
// Port statistics record parser: record queue
// Two-entry FIFO of complete records between the front and the back end.
// ----------------------------------------------------------------------------
module psrp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  psrp_pkg::t_record  i_rec,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output psrp_pkg::t_record  o_rec
);

    psrp_pkg::t_record r_mem [psrp_pkg::QUEUE_DEPTH];
    logic [psrp_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [psrp_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [psrp_pkg::QUEUE_CW-1:0] r_count, n_count;

    assign o_full  = (r_count == psrp_pkg::QUEUE_CW'(psrp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + psrp_pkg::QUEUE_CW'(1);
            2'b01:   n_count = r_count - psrp_pkg::QUEUE_CW'(1);
            default: ;
        endcase
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + psrp_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + psrp_pkg::QUEUE_AW'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("record queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("record queue read while empty");
`endif

endmodule

[rtl/psrp_back.sv]
// ----------------------------------------------------------------------------
// Port statistics record parser: back end
// Takes records from the queue, computes power and status flags and holds
// the finished result in the output register until it is taken.
// ----------------------------------------------------------------------------
module psrp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  psrp_pkg::t_record  i_rec,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_port_number,
    output logic [7:0]         o_protocol_code,
    output logic [7:0]         o_current_32nds,
    output logic [7:0]         o_voltage_8ths,
    output logic [15:0]        o_power_256ths,
    output logic signed [7:0]  o_temperature,
    output logic               o_charging,
    output logic               o_enabled
);

    logic        r_valid;
    logic [3:0]  r_port;
    logic [7:0]  r_protocol;
    logic [7:0]  r_current;
    logic [7:0]  r_voltage;
    logic [15:0] r_power;
    logic [7:0]  r_temp;
    logic        r_charging;
    logic        r_enabled;

    // Load a new record when the output register is free or being drained
    assign o_pop = i_q_valid && (!r_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Compute the result fields
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_port     <= i_rec.port_number;
            r_protocol <= i_rec.protocol_code;
            r_current  <= i_rec.current_32nds;
            r_voltage  <= i_rec.voltage_8ths;
            r_power    <= 16'(i_rec.voltage_8ths) * 16'(i_rec.current_32nds);
            r_temp     <= i_rec.temperature;
            r_charging <= (i_rec.current_32nds != 8'd0);
            r_enabled  <= (i_rec.protocol_code != psrp_pkg::NO_PROTOCOL)
                       || (i_rec.voltage_8ths != 8'd0)
                       || (i_rec.current_32nds != 8'd0);
        end
    end

    assign o_out_valid     = r_valid;
    assign o_port_number   = r_port;
    assign o_protocol_code = r_protocol;
    assign o_current_32nds = r_current;
    assign o_voltage_8ths  = r_voltage;
    assign o_power_256ths  = r_power;
    assign o_temperature   = $signed(r_temp);
    assign o_charging      = r_charging;
    assign o_enabled       = r_enabled;

`ifndef SYNTH
    a_fill_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid && !r_valid |=> r_valid)
        else $error("back end left a queued record waiting with an empty output");
`endif

endmodule

[rtl/port_statistics_record_parser_core.sv]
// ----------------------------------------------------------------------------
// Port statistics record parser core
// Turns a byte stream of power-statistics payloads into one result per port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one payload byte per
//   transaction, with i_last_byte set on the final byte of a payload. A
//   leading 0x00 byte is skipped; the rest is cut into 8-byte port records.
//   Output channel (o_out_valid / i_out_ready) delivers one transaction per
//   complete record while the per-payload port count is below the limit.
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
//   the port limit; write it only while the block is idle.
//   Throughput: one byte per cycle sustained while o_in_ready is high. A
//   result passes from the front through the record queue into the output
//   register. The two-entry record queue sets how long the front keeps
//   accepting bytes while the receiver stalls; with the queue full,
//   o_in_ready drops until the back end drains a record.
//   Reset: synchronous, active low; the port limit returns to 16, the
//   parser returns to payload start and queue and output register empty.
// ----------------------------------------------------------------------------
module port_statistics_record_parser_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_payload_byte,
    input  logic              i_last_byte,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [4:0]        i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [3:0]        o_port_number,
    output logic [7:0]        o_protocol_code,
    output logic [7:0]        o_current_32nds,
    output logic [7:0]        o_voltage_8ths,
    output logic [15:0]       o_power_256ths,
    output logic signed [7:0] o_temperature,
    output logic              o_charging,
    output logic              o_enabled
);

    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              pop;
    psrp_pkg::t_record push_rec;
    psrp_pkg::t_record pop_rec;

    // Assemble records
    psrp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_payload_byte (i_payload_byte),
        .i_last_byte    (i_last_byte),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_push         (push),
        .o_rec          (push_rec),
        .i_q_full       (q_full)
    );

    // Decouple front and back
    psrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (pop_rec)
    );

    // Compute and deliver results
    psrp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_rec           (pop_rec),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_port_number   (o_port_number),
        .o_protocol_code (o_protocol_code),
        .o_current_32nds (o_current_32nds),
        .o_voltage_8ths  (o_voltage_8ths),
        .o_power_256ths  (o_power_256ths),
        .o_temperature   (o_temperature),
        .o_charging      (o_charging),
        .o_enabled       (o_enabled)
    );

endmodule

[tb/port_statistics_record_parser_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Port statistics record parser core: testbench
// Feeds payload byte streams through the valid/ready input channel, rewrites
// the port limit between traffic phases and checks every output transaction
// field by field against an in-bench record parser model or typed results.
// A short table of hand-built payloads runs first, then random payloads
// under several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module port_statistics_record_parser_core_tb;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 40;
    localparam int NUM_PHASES    = 8;

    typedef struct packed {
        logic [3:0]        port_number;
        logic [7:0]        protocol_code;
        logic [7:0]        current_32nds;
        logic [7:0]        voltage_8ths;
        logic [15:0]       power_256ths;
        logic signed [7:0] temperature;
        logic              charging;
        logic              enabled;
    } t_port_result;

    typedef struct packed {
        bit           typed;
        t_port_result result;
    } t_typed_result;

    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        bit           typed;
        t_port_result result;
    } t_stim_row;

    localparam t_port_result NO_RESULT = '0;

    // Hand-built payloads; typed results sit on the byte that closes a record
    localparam t_stim_row DIRECTED [21] = '{
        // leading zero skipped, all-idle record, then a dropped partial record
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, 1'b0, NO_RESULT},
        '{8'hA5, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h3C, 1'b0, 1'b1,
          '{4'd0, 8'hFF, 8'h00, 8'h00, 16'd0, 8'sh80, 1'b0, 1'b0}},
        '{8'h11, 1'b0, 1'b0, NO_RESULT},
        '{8'h22, 1'b1, 1'b0, NO_RESULT},
        // no leading zero, full-scale current and voltage, record ends on last
        '{8'h07, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b1, 1'b1,
          '{4'd0, 8'h07, 8'hFF, 8'hFF, 16'hFE01, 8'sh7F, 1'b1, 1'b1}},
        // one-byte payloads: a skipped zero, then a lone dropped byte
        '{8'h00, 1'b1, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, 1'b0, NO_RESULT}
    };

    // Port limit per phase: extremes, small limits and a random one at the end
    localparam logic [4:0] LIMIT_PLAN [NUM_PHASES] = '{
        5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd2, 5'd0
    };

    // DUT signals
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_in_valid     = 1'b0;
    logic              o_in_ready;
    logic [7:0]        i_payload_byte = '0;
    logic              i_last_byte    = 1'b0;
    logic              i_cfg_valid    = 1'b0;
    logic              o_cfg_ready;
    logic [4:0]        i_cfg_data     = '0;
    logic              o_out_valid;
    logic              i_out_ready    = 1'b0;
    logic [3:0]        o_port_number;
    logic [7:0]        o_protocol_code;
    logic [7:0]        o_current_32nds;
    logic [7:0]        o_voltage_8ths;
    logic [15:0]       o_power_256ths;
    logic signed [7:0] o_temperature;
    logic              o_charging;
    logic              o_enabled;

    // Parser model state
    logic       at_start;
    logic [2:0] record_pos;
    logic [4:0] ports_done;
    logic [4:0] port_limit;
    logic [7:0] held_protocol;
    logic [7:0] held_current;
    logic [7:0] held_voltage;
    logic [7:0] held_temp;

    t_port_result  pending_ports [$];
    t_typed_result typed_results [$];

    int error_count   = 0;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int idle_cycles   = 0;

    port_statistics_record_parser_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_payload_byte  (i_payload_byte),
        .i_last_byte     (i_last_byte),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_port_number   (o_port_number),
        .o_protocol_code (o_protocol_code),
        .o_current_32nds (o_current_32nds),
        .o_voltage_8ths  (o_voltage_8ths),
        .o_power_256ths  (o_power_256ths),
        .o_temperature   (o_temperature),
        .o_charging      (o_charging),
        .o_enabled       (o_enabled)
    );

    always #2 i_clk = ~i_clk;

    task automatic note_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic reset_parser_model();
        at_start      = 1'b1;
        record_pos    = '0;
        ports_done    = '0;
        port_limit    = psrp_pkg::MAX_PORTS_RESET;
        held_protocol = '0;
        held_current  = '0;
        held_voltage  = '0;
        held_temp     = '0;
    endtask

    // Advance the parser model by one byte; flag a record that gets reported
    task automatic predict_port_record(input logic [7:0] data, input logic last,
                                       output bit emitted, output t_port_result res);
        logic [4:0] cap;
        cap     = (port_limit < psrp_pkg::PORT_CAP) ? port_limit : psrp_pkg::PORT_CAP;
        emitted = 1'b0;
        res     = NO_RESULT;
        if (!(at_start && data == psrp_pkg::SKIP_BYTE)) begin
            case (record_pos)
                psrp_pkg::POS_PROTOCOL:    held_protocol = data;
                psrp_pkg::POS_CURRENT:     held_current  = data;
                psrp_pkg::POS_VOLTAGE:     held_voltage  = data;
                psrp_pkg::POS_TEMPERATURE: held_temp     = data;
                default: ;
            endcase
            if (record_pos == psrp_pkg::POS_LAST) begin
                record_pos = '0;
                if (ports_done < cap) begin
                    res.port_number   = ports_done[3:0];
                    res.protocol_code = held_protocol;
                    res.current_32nds = held_current;
                    res.voltage_8ths  = held_voltage;
                    res.power_256ths  = 16'(held_voltage) * 16'(held_current);
                    res.temperature   = held_temp;
                    res.charging      = (held_current != 8'd0);
                    res.enabled       = (held_protocol != psrp_pkg::NO_PROTOCOL) ||
                                        (held_voltage != 8'd0) || (held_current != 8'd0);
                    ports_done        = ports_done + 5'd1;
                    emitted           = 1'b1;
                end
            end else begin
                record_pos = record_pos + 3'd1;
            end
        end
        // return to payload start after the final byte; held bytes stay
        at_start = last;
        if (last) begin
            record_pos = '0;
            ports_done = '0;
        end
    endtask

    task automatic check_result(input t_port_result got, input t_port_result want);
        if (got.port_number != want.port_number)
            note_error($sformatf("port_number got %0d want %0d",
                                 got.port_number, want.port_number));
        if (got.protocol_code != want.protocol_code)
            note_error($sformatf("protocol_code got %02h want %02h",
                                 got.protocol_code, want.protocol_code));
        if (got.current_32nds != want.current_32nds)
            note_error($sformatf("current_32nds got %0d want %0d",
                                 got.current_32nds, want.current_32nds));
        if (got.voltage_8ths != want.voltage_8ths)
            note_error($sformatf("voltage_8ths got %0d want %0d",
                                 got.voltage_8ths, want.voltage_8ths));
        if (got.power_256ths != want.power_256ths)
            note_error($sformatf("power_256ths got %0d want %0d",
                                 got.power_256ths, want.power_256ths));
        if (got.temperature != want.temperature)
            note_error($sformatf("temperature got %0d want %0d",
                                 got.temperature, want.temperature));
        if (got.charging != want.charging)
            note_error($sformatf("charging got %0b want %0b", got.charging, want.charging));
        if (got.enabled != want.enabled)
            note_error($sformatf("enabled got %0b want %0b", got.enabled, want.enabled));
    endtask

    // Track accepted transactions on all three channels at the rising edge
    always @(posedge i_clk) begin
        bit            emitted;
        t_port_result  predicted;
        t_port_result  got;
        t_typed_result tag;
        if (!i_rst_n) begin
            reset_parser_model();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                port_limit = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                predict_port_record(i_payload_byte, i_last_byte, emitted, predicted);
                tag = (typed_results.size() != 0) ? typed_results.pop_front() : '0;
                if (tag.typed)
                    pending_ports.push_back(tag.result);
                else if (emitted)
                    pending_ports.push_back(predicted);
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_port_number, o_protocol_code, o_current_32nds, o_voltage_8ths,
                        o_power_256ths, o_temperature, o_charging, o_enabled};
                if (pending_ports.size() == 0)
                    note_error($sformatf("unexpected result for port %0d", o_port_number));
                else
                    check_result(got, pending_ports.pop_front());
            end
        end
    end

    // Stop the run once no channel has moved a transaction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Present one byte, with random idle cycles ahead of it, and hold until taken
    task automatic send_item(input logic [7:0] data, input logic last,
                             input bit typed, input t_port_result result);
        typed_results.push_back('{typed, result});
        while ($urandom_range(99) < in_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_payload_byte <= data;
        i_last_byte    <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(99);
        if (r < 25) return 8'h00;
        if (r < 35) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    // Build one payload: mostly well-formed records, sometimes random noise
    task automatic send_payload(inout int sent);
        logic [7:0] bytes [$];
        int         nrec;
        int         npart;
        int         r;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(12, 1)) bytes.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) bytes[0] = psrp_pkg::SKIP_BYTE;
        end else begin
            if ($urandom_range(1)) bytes.push_back(psrp_pkg::SKIP_BYTE);
            nrec  = ($urandom_range(99) < 6) ? $urandom_range(17, 16) : $urandom_range(4);
            npart = ($urandom_range(99) < 25) ? $urandom_range(7, 1) : 0;
            repeat (nrec) begin
                r = $urandom_range(99);
                bytes.push_back((r < 25) ? psrp_pkg::NO_PROTOCOL :
                                (r < 35) ? 8'h00 : 8'($urandom_range(255)));
                bytes.push_back(pick_level());
                bytes.push_back(pick_level());
                repeat (5) bytes.push_back(8'($urandom_range(255)));
            end
            repeat (npart) bytes.push_back(8'($urandom_range(255)));
            if (bytes.size() == 0) bytes.push_back(8'($urandom_range(255)));
        end
        foreach (bytes[i])
            send_item(bytes[i], i == bytes.size() - 1, 1'b0, NO_RESULT);
        sent += bytes.size();
    endtask

    // Drop valid and wait out every pending result plus the pipeline depth
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_ports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_port_limit(input logic [4:0] limit);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int sent;
        reset_parser_model();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed payloads at the reset limit, no idling
        foreach (DIRECTED[i])
            send_item(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].typed,
                      DIRECTED[i].result);

        // Random phases: new limit each phase, rotate the idle pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_port_limit((p == NUM_PHASES - 1) ? 5'($urandom_range(31)) : LIMIT_PLAN[p]);
            case (p % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 86; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 86; end
                default: begin in_idle_pct = 27; out_stall_pct = 27; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) send_payload(sent);
        end

        settle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
